// ===== rtl/core/arqst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the affinity ready queue scheduler.
// Used by arqst_front, arqst_back and the top level; depends on nothing.
package arqst_pkg;

  localparam int DEF_MAX_THREADS = 16;
  localparam int DEF_NUM_CPUS    = 2;

  // Function codes on the input word.
  localparam logic [1:0] FN_ADD   = 2'd0;
  localparam logic [1:0] FN_SLEEP = 2'd1;
  localparam logic [1:0] FN_SCHED = 2'd2;
  localparam logic [1:0] FN_BLOCK = 2'd3;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SLEEP,
    OP_SCHED,
    OP_GIVEN,
    OP_BLOCK
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SLP_RD,
    ST_SLP_CMP,
    ST_DRN_RD,
    ST_DRN_CMP,
    ST_CUR,
    ST_SCN_RD,
    ST_SCN_CMP,
    ST_DONE
  } st_t;

  // A classified word as it waits in the queue between front and back.
  typedef struct packed {
    op_t         op;
    logic [3:0]  tid;
    logic [1:0]  mask;
    logic [63:0] wake;
    logic [63:0] now;
    logic [1:0]  sel;
    logic [3:0]  cur;
    logic        requeue;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fq_t;

  typedef struct packed {
    logic [3:0] id;
    logic [1:0] mask;
  } rdy_ent_t;

  typedef struct packed {
    logic [63:0] wake;
    logic [3:0]  id;
    logic [1:0]  mask;
  } slp_ent_t;

endpackage

// ===== rtl/core/arqst_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input words, classifies them and computes the wake time.
// Holds a two-entry queue toward arqst_back; uses arqst_pkg.
module arqst_front #(
  parameter int NUM_CPUS = arqst_pkg::DEF_NUM_CPUS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                valid,
  output logic                stall,
  input  logic [1:0]          func,
  input  logic [3:0]          thread_id,
  input  logic [1:0]          affinity,
  input  logic [31:0]         duration,
  input  logic [63:0]         now,
  input  logic                cpu_id,
  input  logic [3:0]          running_thread,
  input  logic                current_ready,
  input  logic                current_is_idle,
  input  logic                use_given,
  output arqst_pkg::fq_t      fq,
  input  logic                q_pop
);
  import arqst_pkg::*;

  item_t      q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       accept;
  item_t      new_item;

  assign stall  = (cnt == 2'd2);
  assign accept = valid && !stall;

  always_comb begin
    new_item.tid     = thread_id;
    new_item.mask    = affinity;
    new_item.wake    = now + {32'd0, duration};
    new_item.now     = now;
    new_item.cur     = running_thread;
    new_item.requeue = current_ready && !current_is_idle;
    // A CPU number past the configured count matches no mask.
    if (int'(cpu_id) < NUM_CPUS) begin
      new_item.sel = cpu_id ? 2'b10 : 2'b01;
    end else begin
      new_item.sel = 2'b00;
    end
    case (func)
      FN_ADD:   new_item.op = OP_ADD;
      FN_SLEEP: new_item.op = OP_SLEEP;
      FN_SCHED: new_item.op = use_given ? OP_GIVEN : OP_SCHED;
      FN_BLOCK: new_item.op = OP_BLOCK;
      default:  new_item.op = OP_BLOCK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wp] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (accept) begin
        wp <= ~wp;
      end
      if (q_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, accept} - {1'b0, q_pop};
    end
  end

  assign fq.valid = (cnt != 2'd0);
  assign fq.item  = q[rp];

endmodule

// ===== rtl/core/arqst_back.sv =====
`timescale 1ns / 1ps
// Back end: sequencer that owns the ready list, the sleep store and the ready
// marks, and drives the registered result port. Uses arqst_pkg.
module arqst_back #(
  parameter int MAX_THREADS = arqst_pkg::DEF_MAX_THREADS
) (
  input  logic           clk,
  input  logic           rst,
  input  arqst_pkg::fq_t fq,
  output logic           q_pop,
  output logic           result_valid,
  input  logic           result_stall,
  output logic [3:0]     chosen_thread,
  output logic           go_idle,
  output logic           store_full
);
  import arqst_pkg::*;

  localparam int IW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int CW = $clog2(MAX_THREADS + 1);

  // Logical position k in the circular sleep store, counted from the head.
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = {{(CW + 1 - IW){1'b0}}, h} + {1'b0, k};
    if (s >= (CW + 1)'(MAX_THREADS)) begin
      s = s - (CW + 1)'(MAX_THREADS);
    end
    return s[IW-1:0];
  endfunction

  rdy_ent_t rmem [MAX_THREADS];
  slp_ent_t smem [MAX_THREADS];
  rdy_ent_t rrd;
  slp_ent_t srd;

  logic          rwe, swe;
  logic [IW-1:0] rwa, rra, swa, sra;
  rdy_ent_t      rwd;
  slp_ent_t      swd;

  st_t           state, state_next;
  item_t         it, it_next;
  logic [CW-1:0] rcnt, rcnt_next, scount, scount_next;
  logic [IW-1:0] shead, shead_next;
  logic [CW-1:0] pos, pos_next, r, r_next, w, w_next;
  logic          found, found_next;
  logic [3:0]    nxt, nxt_next;
  logic          idle, idle_next, full, full_next;
  logic [15:0]   marks, marks_next;
  logic          ov_next;
  logic [3:0]    o_next_n;
  logic          o_idle_n, o_full_n, o_load;

  logic          push, keep;
  logic [3:0]    pid;
  logic [1:0]    pmask;

  always_ff @(posedge clk) begin
    if (rwe) begin
      rmem[rwa] <= rwd;
    end
    rrd <= rmem[rra];
  end

  always_ff @(posedge clk) begin
    if (swe) begin
      smem[swa] <= swd;
    end
    srd <= smem[sra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rcnt         <= '0;
      scount       <= '0;
      shead        <= '0;
      marks        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      rcnt         <= rcnt_next;
      scount       <= scount_next;
      shead        <= shead_next;
      marks        <= marks_next;
      result_valid <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    it    <= it_next;
    pos   <= pos_next;
    r     <= r_next;
    w     <= w_next;
    found <= found_next;
    nxt   <= nxt_next;
    idle  <= idle_next;
    full  <= full_next;
    if (o_load) begin
      chosen_thread <= o_next_n;
      go_idle       <= o_idle_n;
      store_full    <= o_full_n;
    end
  end

  always_comb begin
    state_next  = state;
    it_next     = it;
    rcnt_next   = rcnt;
    scount_next = scount;
    shead_next  = shead;
    pos_next    = pos;
    r_next      = r;
    w_next      = w;
    found_next  = found;
    nxt_next    = nxt;
    idle_next   = idle;
    full_next   = full;
    marks_next  = marks;
    q_pop       = 1'b0;
    rwe         = 1'b0;
    rwa         = rcnt[IW-1:0];
    rwd         = '0;
    rra         = r[IW-1:0];
    swe         = 1'b0;
    swa         = shead;
    swd         = '0;
    sra         = shead;
    push        = 1'b0;
    keep        = 1'b0;
    pid         = it.cur;
    pmask       = it.mask;
    o_load      = 1'b0;
    o_next_n    = nxt;
    o_idle_n    = idle;
    o_full_n    = full;
    ov_next     = result_valid && result_stall;

    case (state)
      ST_IDLE: begin
        if (fq.valid) begin
          q_pop     = 1'b1;
          it_next   = fq.item;
          nxt_next  = 4'd0;
          idle_next = 1'b0;
          full_next = 1'b0;
          case (fq.item.op)
            OP_ADD: begin
              push       = 1'b1;
              pid        = fq.item.tid;
              pmask      = fq.item.mask;
              state_next = ST_DONE;
            end
            OP_SLEEP: begin
              if (scount == CW'(MAX_THREADS)) begin
                full_next  = 1'b1;
                state_next = ST_DONE;
              end else begin
                pos_next   = scount;
                state_next = ST_SLP_RD;
              end
            end
            OP_BLOCK: begin
              marks_next[fq.item.tid] = 1'b0;
              state_next              = ST_DONE;
            end
            OP_GIVEN: begin
              nxt_next   = fq.item.tid;
              state_next = ST_DONE;
            end
            OP_SCHED: state_next = ST_DRN_RD;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      // Insertion walks from the tail toward the head, moving later sleepers
      // up one place until it finds the slot after all equal or earlier ones.
      ST_SLP_RD: begin
        if (pos == '0) begin
          swe                    = 1'b1;
          swa                    = shead;
          swd                    = '{wake: it.wake, id: it.tid, mask: it.mask};
          scount_next            = scount + 1'b1;
          marks_next[it.tid]     = 1'b0;
          state_next             = ST_DONE;
        end else begin
          sra        = phys(shead, pos - 1'b1);
          state_next = ST_SLP_CMP;
        end
      end
      ST_SLP_CMP: begin
        swe = 1'b1;
        swa = phys(shead, pos);
        if (srd.wake <= it.wake) begin
          swd                = '{wake: it.wake, id: it.tid, mask: it.mask};
          scount_next        = scount + 1'b1;
          marks_next[it.tid] = 1'b0;
          state_next         = ST_DONE;
        end else begin
          swd        = srd;
          pos_next   = pos - 1'b1;
          state_next = ST_SLP_RD;
        end
      end
      ST_DRN_RD: begin
        if (scount == '0) begin
          state_next = ST_CUR;
        end else begin
          sra        = shead;
          state_next = ST_DRN_CMP;
        end
      end
      ST_DRN_CMP: begin
        if (srd.wake < it.now) begin
          shead_next  = (shead == IW'(MAX_THREADS - 1)) ? '0 : shead + 1'b1;
          scount_next = scount - 1'b1;
          push        = 1'b1;
          pid         = srd.id;
          pmask       = srd.mask;
          state_next  = ST_DRN_RD;
        end else begin
          state_next = ST_CUR;
        end
      end
      ST_CUR: begin
        push       = it.requeue;
        r_next     = '0;
        w_next     = '0;
        found_next = 1'b0;
        state_next = ST_SCN_RD;
      end
      ST_SCN_RD: begin
        if (r == rcnt) begin
          rcnt_next  = w;
          idle_next  = !found;
          state_next = ST_DONE;
        end else begin
          state_next = ST_SCN_CMP;
        end
      end
      // Entries are compacted in place: the write slot never passes the read slot.
      ST_SCN_CMP: begin
        if (found) begin
          keep = 1'b1;
        end else if (!marks[rrd.id]) begin
          keep = 1'b0;
        end else if (|(rrd.mask & it.sel)) begin
          found_next = 1'b1;
          nxt_next   = rrd.id;
        end else begin
          keep = 1'b1;
        end
        if (keep) begin
          rwe    = 1'b1;
          rwa    = w[IW-1:0];
          rwd    = rrd;
          w_next = w + 1'b1;
        end
        r_next     = r + 1'b1;
        state_next = ST_SCN_RD;
      end
      ST_DONE: begin
        if (!result_valid || !result_stall) begin
          o_load     = 1'b1;
          ov_next    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase

    if (push) begin
      if (rcnt == CW'(MAX_THREADS)) begin
        full_next = 1'b1;
      end else begin
        rwe             = 1'b1;
        rwa             = rcnt[IW-1:0];
        rwd             = '{id: pid, mask: pmask};
        rcnt_next       = rcnt + 1'b1;
        marks_next[pid] = 1'b1;
      end
    end
  end

  a_rcnt_range: assert property (@(posedge clk) disable iff (rst)
    rcnt <= CW'(MAX_THREADS)) else $error("ready count past capacity");
  a_scount_range: assert property (@(posedge clk) disable iff (rst)
    scount <= CW'(MAX_THREADS)) else $error("sleep count past capacity");
  a_compact: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCN_RD || state == ST_SCN_CMP) |-> (w <= r))
    else $error("compaction write slot passed read slot");
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_DONE)
    else $error("result raised outside completion");

endmodule

// ===== rtl/core/affinity_ready_queue_with_sleep_timers.sv =====
`timescale 1ns / 1ps
// Hardware thread scheduler: FIFO ready list with CPU affinity masks and a
// wake-time ordered sleep store. Add, block and forced schedule complete
// without a walk. A sleep walks from the tail over the sleepers with a later
// wake time and shifts each up one entry through the single read port of the
// sleep memory. A schedule first wakes the sleepers whose wake time has passed,
// then requeues the current thread, then walks the ready list once, reading
// one entry at a time from each memory. A stalled result holds the back end
// until it is taken. A two-word queue in front and a registered result let
// both sides stall independently.
module affinity_ready_queue_with_sleep_timers #(
  parameter int MAX_THREADS = arqst_pkg::DEF_MAX_THREADS,
  parameter int NUM_CPUS    = arqst_pkg::DEF_NUM_CPUS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic [1:0]  func,
  input  logic [3:0]  thread_id,
  input  logic [1:0]  affinity,
  input  logic [31:0] duration,
  input  logic [63:0] now,
  input  logic        cpu_id,
  input  logic [3:0]  running_thread,
  input  logic        current_ready,
  input  logic        current_is_idle,
  input  logic        use_given,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [3:0]  chosen_thread,
  output logic        go_idle,
  output logic        store_full
);
  import arqst_pkg::*;

  fq_t  fq;
  logic q_pop;

  arqst_front #(.NUM_CPUS(NUM_CPUS)) u_front (
    .clk, .rst, .valid, .stall, .func, .thread_id, .affinity, .duration, .now,
    .cpu_id, .running_thread, .current_ready, .current_is_idle, .use_given,
    .fq, .q_pop
  );

  arqst_back #(.MAX_THREADS(MAX_THREADS)) u_back (
    .clk, .rst, .fq, .q_pop, .result_valid, .result_stall,
    .chosen_thread, .go_idle, .store_full
  );

endmodule
